FILE: rtl/core/value_noise_soup_defines.svh
// ---------------------------------------------------------------------------
// Value noise soup assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef VALUE_NOISE_SOUP_DEFINES_SVH
`define VALUE_NOISE_SOUP_DEFINES_SVH
`ifndef SYNTHESIS
`define VNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("value_noise_soup: assertion failed");
`define VNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("value_noise_soup: assertion failed");
`else
`define VNS_ASSERT_IMP(lbl, ante, cons)
`define VNS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/vns_pkg.sv
// ---------------------------------------------------------------------------
// Value noise soup package
// Request and result types, register indexes and fixed-point constants.
// ---------------------------------------------------------------------------
package vns_pkg;

  typedef struct packed {
    logic               func;
    logic [11:0]        x;
    logic [11:0]        y;
    logic [1:0]         channel;
    logic [11:0]        entry_index;
    logic signed [15:0] entry_value;
  } vns_req_t;

  typedef struct packed {
    logic [14:0] level_red;
    logic [14:0] level_green;
    logic [14:0] level_blue;
  } vns_res_t;

  typedef enum logic [1:0] {
    REG_INV_SCALE  = 2'd0,
    REG_CELL_COUNT = 2'd1,
    REG_BASE_LEVEL = 2'd2
  } vns_reg_t;

  localparam logic       FUNC_WRITE = 1'b0;
  localparam logic       FUNC_EVAL  = 1'b1;

  localparam int         CFG_W      = 17;
  localparam int         GW         = 29;   // pixel times reciprocal
  localparam int         CW         = 13;   // integer cell width
  localparam logic [16:0] INV_SCALE_RST  = 17'd65536;
  localparam logic [6:0]  CELL_COUNT_RST = 7'd64;
  localparam logic [15:0] BASE_LEVEL_RST = 16'd1638;
  localparam logic [17:0] SMOOTH_K       = 18'd196608;  // 3.0 in Q16
  localparam logic [14:0] LEVEL_MAX      = 15'd16384;   // 1.0 in Q1.14

endpackage

FILE: rtl/core/value_noise_soup.sv
// ---------------------------------------------------------------------------
// Value noise soup
// Three-channel 2D lattice value noise with smoothstep bilinear blending.
// ---------------------------------------------------------------------------
// One request is taken every clock; busy stays low. An evaluate request gives
// its result on done from the eight-stage pipeline (multiply, two modulo
// halves with smoothstep, address, lattice RAM read, products, sum, round
// and clamp). A write request passes through the multiply, modulo and address
// stages, is written into the lattice RAMs in the RAM stage and gives no result. Each
// channel keeps four copies of its lattice, one per corner, so all twelve
// corners are read in the same cycle. The receiver cannot stall the result.
`include "value_noise_soup_defines.svh"

module value_noise_soup #(
  parameter int MAX_CELLS = 64,
  parameter int CHANNELS  = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  vns_pkg::vns_req_t     request,
  output logic                  done,
  output vns_pkg::vns_res_t     result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [vns_pkg::CFG_W-1:0] cfg_wdata
);
  import vns_pkg::*;

  localparam int PLANE = MAX_CELLS * MAX_CELLS;
  localparam int AW    = $clog2(PLANE);
  localparam int NW    = $clog2(MAX_CELLS + 1);
  localparam int DW    = CW + NW;
  localparam int NCH   = (CHANNELS < 3) ? CHANNELS : 3;

  // configuration
  logic [16:0]        inv_scale;
  logic [6:0]         cell_count;
  logic signed [15:0] base_level;
  logic [NW-1:0]      n;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale  <= INV_SCALE_RST;
      cell_count <= CELL_COUNT_RST;
      base_level <= BASE_LEVEL_RST;
    end else if (cfg_we) begin
      case (vns_reg_t'(cfg_index))
        REG_INV_SCALE:  inv_scale  <= cfg_wdata;
        REG_CELL_COUNT: cell_count <= cfg_wdata[6:0];
        REG_BASE_LEVEL: base_level <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cell_count) < 32'd2) begin
      n = NW'(2);
    end else if (32'(cell_count) > 32'(MAX_CELLS)) begin
      n = NW'(MAX_CELLS);
    end else begin
      n = NW'(cell_count);
    end
  end

  assign busy = 1'b0;

  // stage 1: take request, scale coordinates
  logic           s1_v;
  vns_req_t       s1_req;
  logic [GW-1:0]  s1_gx, s1_gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
    end
    s1_req <= request;
    s1_gx  <= GW'(request.x * inv_scale);
    s1_gy  <= GW'(request.y * inv_scale);
  end

  // stage 2: upper modulo steps, fraction squared
  logic [CW-1:0]  m2_x, m2_y;
  logic [DW-1:0]  d2;

  always_comb begin
    m2_x = s1_gx[GW-1:16];
    m2_y = s1_gy[GW-1:16];
    d2   = '0;
    for (int k = CW - 1; k >= CW - 7; k--) begin
      d2 = DW'(n) << k;
      if (DW'(m2_x) >= d2) m2_x = m2_x - CW'(d2);
      if (DW'(m2_y) >= d2) m2_y = m2_y - CW'(d2);
    end
  end

  logic           s2_v;
  vns_req_t       s2_req;
  logic [CW-1:0]  s2_rx, s2_ry;
  logic [31:0]    s2_ffx, s2_ffy;
  logic [17:0]    s2_tx, s2_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_req <= s1_req;
    s2_rx  <= m2_x;
    s2_ry  <= m2_y;
    s2_ffx <= s1_gx[15:0] * s1_gx[15:0];
    s2_ffy <= s1_gy[15:0] * s1_gy[15:0];
    s2_tx  <= SMOOTH_K - {1'b0, s1_gx[15:0], 1'b0};
    s2_ty  <= SMOOTH_K - {1'b0, s1_gy[15:0], 1'b0};
  end

  // stage 3: lower modulo steps, finish smoothstep
  logic [CW-1:0]  m3_x, m3_y;
  logic [DW-1:0]  d3;
  logic [49:0]    sm3_x, sm3_y;

  always_comb begin
    m3_x = s2_rx;
    m3_y = s2_ry;
    d3   = '0;
    for (int k = CW - 8; k >= 0; k--) begin
      d3 = DW'(n) << k;
      if (DW'(m3_x) >= d3) m3_x = m3_x - CW'(d3);
      if (DW'(m3_y) >= d3) m3_y = m3_y - CW'(d3);
    end
    sm3_x = s2_ffx * s2_tx;
    sm3_y = s2_ffy * s2_ty;
  end

  logic           s3_v;
  vns_req_t       s3_req;
  logic [NW-1:0]  s3_rx, s3_ry;
  logic [15:0]    s3_sx, s3_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_req <= s2_req;
    s3_rx  <= NW'(m3_x);
    s3_ry  <= NW'(m3_y);
    s3_sx  <= sm3_x[47:32];
    s3_sy  <= sm3_y[47:32];
  end

  // stage 4: neighbour wrap and corner addresses
  logic [NW-1:0]  rx1, ry1;
  logic [NW:0]    rx_inc, ry_inc;
  logic [AW-1:0]  addr4 [4];
  logic           wr_ok;

  always_comb begin
    rx_inc = {1'b0, s3_rx} + 1'b1;
    ry_inc = {1'b0, s3_ry} + 1'b1;
    rx1 = (rx_inc == {1'b0, n}) ? '0 : NW'(rx_inc);
    ry1 = (ry_inc == {1'b0, n}) ? '0 : NW'(ry_inc);
    addr4[0] = AW'(s3_ry * n + s3_rx);
    addr4[1] = AW'(s3_ry * n + rx1);
    addr4[2] = AW'(ry1 * n + s3_rx);
    addr4[3] = AW'(ry1 * n + rx1);
    wr_ok = s3_v && (s3_req.func == FUNC_WRITE)
            && (17'(s3_req.entry_index) < 17'(PLANE));
  end

  logic               s4_v, s4_we;
  logic [1:0]         s4_ch;
  logic [AW-1:0]      s4_waddr;
  logic signed [15:0] s4_wdata;
  logic [AW-1:0]      s4_addr [4];
  logic [15:0]        s4_sx, s4_sy;
  logic [31:0]        s4_sxy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v  <= 1'b0;
      s4_we <= 1'b0;
    end else begin
      s4_v  <= s3_v && (s3_req.func == FUNC_EVAL);
      s4_we <= wr_ok;
    end
    s4_ch    <= s3_req.channel;
    s4_waddr <= AW'(s3_req.entry_index);
    s4_wdata <= s3_req.entry_value;
    for (int k = 0; k < 4; k++) s4_addr[k] <= addr4[k];
    s4_sx  <= s3_sx;
    s4_sy  <= s3_sy;
    s4_sxy <= s3_sx * s3_sy;
  end

  // stage 5: lattice RAMs, one copy per corner
  logic signed [15:0] s5_rd [3][4];
  logic               s5_v;
  logic [15:0]        s5_sx, s5_sy;
  logic [31:0]        s5_sxy;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    for (genvar k = 0; k < 4; k++) begin : g_corner
      if (c < NCH) begin : g_ram
        logic signed [15:0] mem [PLANE];
        always_ff @(posedge clk) begin
          if (s4_we && (s4_ch == 2'(c))) begin
            mem[s4_waddr] <= s4_wdata;
          end
          s5_rd[c][k] <= mem[s4_addr[k]];
        end
      end else begin : g_none
        assign s5_rd[c][k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= s4_v;
    end
    s5_sx  <= s4_sx;
    s5_sy  <= s4_sy;
    s5_sxy <= s4_sxy;
  end

  // stage 6: blend products
  logic               s6_v;
  logic signed [15:0] s6_a   [3];
  logic signed [33:0] s6_pb  [3];
  logic signed [33:0] s6_pc  [3];
  logic signed [50:0] s6_pd  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else begin
      s6_v <= s5_v;
    end
    for (int c = 0; c < 3; c++) begin
      s6_a[c]  <= s5_rd[c][0];
      s6_pb[c] <= (17'(s5_rd[c][1]) - 17'(s5_rd[c][0])) * $signed({1'b0, s5_sx});
      s6_pc[c] <= (17'(s5_rd[c][2]) - 17'(s5_rd[c][0])) * $signed({1'b0, s5_sy});
      s6_pd[c] <= (18'(s5_rd[c][0]) - 18'(s5_rd[c][1]) - 18'(s5_rd[c][2])
                   + 18'(s5_rd[c][3])) * $signed({1'b0, s5_sxy});
    end
  end

  // stage 7: sum with rounding bias
  logic               s7_v;
  logic signed [53:0] s7_acc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else begin
      s7_v <= s6_v;
    end
    for (int c = 0; c < 3; c++) begin
      s7_acc[c] <= (54'(s6_a[c]) <<< 32) + (54'(s6_pb[c]) <<< 16)
                   + (54'(s6_pc[c]) <<< 16) + 54'(s6_pd[c])
                   + (54'sd1 <<< 31);
    end
  end

  // stage 8: reduce, add base, clamp
  logic signed [21:0] lv [3];
  logic [14:0]        lc [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lv[c] = 22'(s7_acc[c] >>> 32) + 22'(base_level);
      if (lv[c] < 0) begin
        lc[c] = '0;
      end else if (lv[c] > 22'(LEVEL_MAX)) begin
        lc[c] = LEVEL_MAX;
      end else begin
        lc[c] = 15'(lv[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s7_v;
    end
    result.level_red   <= lc[0];
    result.level_green <= lc[1];
    result.level_blue  <= lc[2];
  end

  `VNS_ASSERT_IMP(a_level_range, done, (result.level_red <= LEVEL_MAX && result.level_green <= LEVEL_MAX && result.level_blue <= LEVEL_MAX))
  `VNS_ASSERT_IMP(a_eval_latency, start && !busy && request.func == FUNC_EVAL, ##8 done)
  `VNS_ASSERT_IMP(a_write_silent, start && !busy && request.func == FUNC_WRITE, ##8 !done)
  `VNS_ASSERT_IMP(a_wrap_range, s3_v && s3_req.func == FUNC_EVAL, (s3_rx < n && s3_ry < n))
  `VNS_ASSERT_NXT(a_ram_order, wr_ok, !s4_v)

endmodule
